// File: rtl/rdse_pkg.sv
package rdse_pkg;

    localparam int DIGIT_W = 6;

    localparam logic [7:0] ASCII_ZERO        = 8'h30;
    localparam logic [7:0] ASCII_LETTER_BASE = 8'h57;  // 'a' - 10
    localparam logic [7:0] ASCII_MINUS       = 8'h2d;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [DIGIT_W-1:0] MIN_BASE      = 6'd2;
    localparam logic [DIGIT_W-1:0] MAX_BASE      = 6'd36;

    typedef struct packed {
        logic [31:0]        value;
        logic [DIGIT_W-1:0] base;
        logic               signed_mode;
    } item_beat_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_beat_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT_SIGN,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] dgt);
        logic [7:0] ext;
        ext = {2'b00, dgt};
        if (dgt < DECIMAL_LIMIT)
            return ASCII_ZERO + ext;
        else
            return ASCII_LETTER_BASE + ext;
    endfunction

endpackage

// File: rtl/rdse_digit_stack.sv
// LIFO built as a shift line: push shifts toward the deep end, pop shifts back.
module rdse_digit_stack #(
    parameter int DEPTH = 32
) (
    input  logic                         clk,
    input  rdse_pkg::stack_ctrl_t        ctrl,
    input  logic [rdse_pkg::DIGIT_W-1:0] push_digit,
    output logic [rdse_pkg::DIGIT_W-1:0] top_digit
);

    logic [rdse_pkg::DIGIT_W-1:0] stack_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stack_reg[0] <= push_digit;
            for (int i = 1; i < DEPTH; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end
        else if (ctrl.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign top_digit = stack_reg[0];

endmodule

// File: rtl/radix_digit_string_emitter.sv
// Converts one value per input beat into ASCII digits in base 2..36, most
// significant first, with a leading '-' for negatives in signed mode and last
// set on the final character. Digits come from a bit-serial restoring divider
// that retires one quotient bit per cycle; digits are pushed on a LIFO and then
// popped out at one character per cycle while the output is not stalled. A new
// item is taken once the last character of the previous one sits in the output
// register.
module radix_digit_string_emitter #(
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  rdse_pkg::item_beat_t item_data,
    output logic                 text_valid,
    input  logic                 text_stall,
    output rdse_pkg::text_beat_t text_data
);

    localparam int W       = VALUE_BITS;
    localparam int IN_W    = (W < 32) ? W : 32;
    localparam int CNT_W   = $clog2(W);
    localparam int DEPTH_W = $clog2(W + 1);
    localparam int DG_W    = rdse_pkg::DIGIT_W;
    localparam logic [CNT_W-1:0]   LAST_BIT  = CNT_W'(W - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    rdse_pkg::state_t     state_reg, state_next;
    logic [W-1:0]         num_reg, num_next;
    logic [DG_W-1:0]      rem_reg, rem_next;
    logic [DG_W-1:0]      base_reg, base_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 qnz_reg, qnz_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    rdse_pkg::text_beat_t out_data_reg, out_data_next;

    rdse_pkg::stack_ctrl_t stack_ctrl;
    logic [DG_W-1:0]       top_digit;

    logic [W-1:0]    in_val;
    logic            in_neg;
    logic [DG_W:0]   trial;
    logic [DG_W:0]   trial_sub;
    logic            ge;
    logic [DG_W-1:0] digit;
    logic            out_free;

    assign in_val    = W'(item_data.value[IN_W-1:0]);
    assign in_neg    = item_data.signed_mode & in_val[W-1];
    assign trial     = {rem_reg, num_reg[W-1]};
    assign ge        = trial >= {1'b0, base_reg};
    assign trial_sub = ge ? (trial - {1'b0, base_reg}) : trial;
    assign digit     = trial_sub[DG_W-1:0];
    assign out_free  = !out_valid_reg || !text_stall;

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        bit_cnt_next   = bit_cnt_reg;
        depth_next     = depth_reg;
        qnz_next       = qnz_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && text_stall;
        out_data_next  = out_data_reg;
        stack_ctrl     = '0;

        case (state_reg)
            rdse_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    num_next     = in_neg ? (~in_val + W'(1)) : in_val;
                    neg_next     = in_neg;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    depth_next   = '0;
                    qnz_next     = 1'b0;
                    if (item_data.base < rdse_pkg::MIN_BASE)
                        base_next = rdse_pkg::MIN_BASE;
                    else if (item_data.base > rdse_pkg::MAX_BASE)
                        base_next = rdse_pkg::MAX_BASE;
                    else
                        base_next = item_data.base;
                    state_next = rdse_pkg::ST_DIVIDE;
                end
            end

            rdse_pkg::ST_DIVIDE:
            begin
                // quotient bits rotate in at the bottom as dividend bits leave the top
                num_next     = {num_reg[W-2:0], ge};
                rem_next     = digit;
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                qnz_next     = qnz_reg | ge;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    stack_ctrl.push = 1'b1;
                    depth_next      = depth_reg + DEPTH_ONE;
                    rem_next        = '0;
                    bit_cnt_next    = '0;
                    qnz_next        = 1'b0;
                    if (!(qnz_reg | ge))
                        state_next = neg_reg ? rdse_pkg::ST_EMIT_SIGN : rdse_pkg::ST_EMIT;
                end
            end

            rdse_pkg::ST_EMIT_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.character = rdse_pkg::ASCII_MINUS;
                    out_data_next.last      = 1'b0;
                    state_next              = rdse_pkg::ST_EMIT;
                end
            end

            rdse_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.character = rdse_pkg::digit_to_ascii(top_digit);
                    out_data_next.last      = (depth_reg == DEPTH_ONE);
                    stack_ctrl.pop          = 1'b1;
                    depth_next              = depth_reg - DEPTH_ONE;
                    if (depth_reg == DEPTH_ONE)
                        state_next = rdse_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rdse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdse_pkg::ST_IDLE;
            bit_cnt_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        base_reg     <= base_next;
        qnz_reg      <= qnz_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    rdse_digit_stack #(
        .DEPTH (W)
    ) u_stack (
        .clk        (clk),
        .ctrl       (stack_ctrl),
        .push_digit (digit),
        .top_digit  (top_digit)
    );

    assign item_stall = (state_reg != rdse_pkg::ST_IDLE);
    assign text_valid = out_valid_reg;
    assign text_data  = out_data_reg;

endmodule

// File: dv/digit_string_checker.sv
module digit_string_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  rdse_pkg::item_beat_t item_data,
    input  logic                 text_valid,
    input  logic                 text_stall,
    input  rdse_pkg::text_beat_t text_data,
    output int                   error_count,
    output int                   chars_owed
);

    import rdse_pkg::*;

    text_beat_t expected_text[$];
    text_beat_t want;

    // Queue the characters one value should produce, sign first.
    function automatic void spell_value(input item_beat_t it);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [31:0] rem;
        logic [5:0]  dgt;
        logic [7:0]  digits[$];
        text_beat_t  beat;
        radix = {26'd0, it.base};
        if (it.base < MIN_BASE)
            radix = {26'd0, MIN_BASE};
        else if (it.base > MAX_BASE)
            radix = {26'd0, MAX_BASE};
        mag = it.value;
        if (it.signed_mode && mag[31])
        begin
            // wraps for the most negative value, which gives the right magnitude
            mag = ~mag + 32'd1;
            beat.character = ASCII_MINUS;
            beat.last = 1'b0;
            expected_text.push_back(beat);
        end
        do
        begin
            rem = mag % radix;
            dgt = rem[5:0];
            if (dgt < DECIMAL_LIMIT)
                digits.push_front(ASCII_ZERO + {2'b00, dgt});
            else
                digits.push_front(ASCII_LETTER_BASE + {2'b00, dgt});
            mag = mag / radix;
        end
        while (mag != 0);
        foreach (digits[i])
        begin
            beat.character = digits[i];
            beat.last = (i == digits.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_text.delete();
            error_count = 0;
            chars_owed <= 0;
        end
        else
        begin
            // outgoing beat always belongs to an older item, so check it first
            if (text_valid && !text_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected beat: expected none, actual char %h last %b",
                             $time, text_data.character, text_data.last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_data.character !== want.character)
                    begin
                        error_count++;
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.character, text_data.character);
                    end
                    if (text_data.last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, text_data.last);
                    end
                end
            end
            if (item_valid && !item_stall)
                spell_value(item_data);
            chars_owed <= expected_text.size();
        end
    end

endmodule

// File: dv/tb.sv
module tb;

    import rdse_pkg::*;

    localparam int LIMIT       = 1500000;
    localparam int HOLD_AT     = 50;
    localparam int HOLD_CYCLES = 500;
    localparam int CALM_FROM   = 80;
    localparam int CALM_TO     = 110;
    localparam int N_RANDOM    = 110;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_beat_t item_data;
    logic       text_valid;
    logic       text_stall;
    text_beat_t text_data;

    int errors;
    int chars_owed;
    int sent_count = 0;
    bit calm = 1'b0;
    int cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    radix_digit_string_emitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_data  (text_data)
    );

    digit_string_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_data   (item_data),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_data   (text_data),
        .error_count (errors),
        .chars_owed  (chars_owed)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // text receiver: random stalls, one long hold-off, a calm stretch
    initial
    begin
        int hold_left;
        bit hold_done;
        text_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                text_stall <= 1'b1;
            end
            else if (calm)
                text_stall <= 1'b0;
            else
                text_stall <= ($urandom_range(0, 99) < 35);
        end
    end

    initial
    begin
        item_beat_t  plan[$];
        logic [31:0] v;
        logic [5:0]  b;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_data = '0;

        // zeros, widest strings, most negative value, digit edges, clamped bases
        plan.push_back('{32'h0000_0000, 6'd10, 1'b0});
        plan.push_back('{32'h0000_0000, 6'd2,  1'b1});
        plan.push_back('{32'hffff_ffff, 6'd2,  1'b0});
        plan.push_back('{32'h8000_0000, 6'd2,  1'b1});
        plan.push_back('{32'h8000_0000, 6'd10, 1'b1});
        plan.push_back('{32'hffff_ffff, 6'd16, 1'b1});
        plan.push_back('{32'hffff_ffff, 6'd36, 1'b0});
        plan.push_back('{32'h7fff_ffff, 6'd10, 1'b1});
        plan.push_back('{32'h1234_5678, 6'd16, 1'b0});
        plan.push_back('{32'd35,        6'd36, 1'b0});
        plan.push_back('{32'd10,        6'd11, 1'b0});
        plan.push_back('{32'd9,         6'd10, 1'b1});
        plan.push_back('{32'd5,         6'd0,  1'b0});
        plan.push_back('{32'd5,         6'd1,  1'b1});
        plan.push_back('{32'd1295,      6'd37, 1'b0});
        plan.push_back('{32'hffff_ffff, 6'd63, 1'b1});
        plan.push_back('{32'd1,         6'd3,  1'b1});
        plan.push_back('{32'h8000_0000, 6'd36, 1'b0});
        plan.push_back('{32'hdead_beef, 6'd8,  1'b1});
        plan.push_back('{32'd36,        6'd36, 1'b0});

        for (int n = 0; n < N_RANDOM; n++)
        begin
            case ($urandom_range(0, 4))
                0: v = $urandom;
                1: v = $urandom_range(0, 1000);
                2: v = $urandom >> $urandom_range(0, 31);
                3: v = $urandom | 32'h8000_0000;
                default: v = 32'd0 - $urandom_range(0, 1000);
            endcase
            if ($urandom_range(0, 9) == 0)
                b = 6'($urandom_range(0, 63));
            else
                b = 6'($urandom_range(2, 36));
            plan.push_back('{v, b, 1'($urandom_range(0, 1))});
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            calm <= (i >= CALM_FROM && i < CALM_TO);
            if (!(i >= CALM_FROM && i < CALM_TO))
            begin
                while ($urandom_range(0, 99) < 35)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            item_valid <= 1'b1;
            item_data <= plan[i];
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            sent_count <= i + 1;
        end
        item_valid <= 1'b0;
        calm <= 1'b0;

        // let the checker count the final beat before reading its backlog
        @(posedge clk);
        while (chars_owed != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/rdse_pkg.sv
rtl/rdse_digit_stack.sv
rtl/radix_digit_string_emitter.sv
dv/digit_string_checker.sv
dv/tb.sv
